// ===== rtl/rbd_pkg.sv =====
// Shared constants, types and channel arithmetic for the RGB565 box downsampler.
`timescale 1ns / 1ps
package rbd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int DIM_W      = 11;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PAIR_DEPTH = MAX_WIDTH / 2;
  localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
  localparam int QUAD_DEPTH = MAX_WIDTH / 4;
  localparam int QUAD_AW    = $clog2(QUAD_DEPTH);
  localparam int SUM_W      = 19;
  localparam int PIX_W      = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FACTOR_MODE  = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic               pair_wr;
    logic               pair_rd;
    logic [PAIR_AW-1:0] pair_addr;
    sum_t               pair_wdata;
    logic               quad_wr;
    logic               quad_rd;
    logic [QUAD_AW-1:0] quad_addr;
    sum_t               quad_wdata;
  } rbd_store_req_t;

  // per-channel sum of two RGB565 pixels: red 18:13, green 12:6, blue 5:0
  function automatic sum_t pair_sum(input pix_t a, input pix_t b);
    logic [5:0] r;
    logic [6:0] g;
    logic [5:0] bl;
    r  = {1'b0, a[15:11]} + {1'b0, b[15:11]};
    g  = {1'b0, a[10:5]} + {1'b0, b[10:5]};
    bl = {1'b0, a[4:0]} + {1'b0, b[4:0]};
    return {r, g, bl};
  endfunction

  // floor of the four-way per-channel average of two pair sums
  function automatic pix_t quad_average(input sum_t s, input sum_t t);
    logic [6:0] r;
    logic [7:0] g;
    logic [6:0] bl;
    r  = {1'b0, s[18:13]} + {1'b0, t[18:13]};
    g  = {1'b0, s[12:6]} + {1'b0, t[12:6]};
    bl = {1'b0, s[5:0]} + {1'b0, t[5:0]};
    return {r[6:2], g[7:2], bl[6:2]};
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] max_v);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) res = DIM_W'(1);
    else if (v > max_v) res = max_v;
    return res;
  endfunction

endpackage

// ===== rtl/rbd_line_stores.sv =====
// Line stores: pair sums of the upper row and quad sums of the upper 2x2 row.
`timescale 1ns / 1ps
module rbd_line_stores
  import rbd_pkg::*;
(
  input  logic           clk,
  input  rbd_store_req_t req,
  output sum_t           pair_rdata,
  output sum_t           quad_rdata
);

  sum_t pair_mem [PAIR_DEPTH];
  sum_t quad_mem [QUAD_DEPTH];
  sum_t pair_rdata_r;
  sum_t quad_rdata_r;

  always_ff @(posedge clk) begin
    if (req.pair_wr) begin
      pair_mem[req.pair_addr] <= req.pair_wdata;
    end
    if (req.pair_rd) begin
      pair_rdata_r <= pair_mem[req.pair_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.quad_wr) begin
      quad_mem[req.quad_addr] <= req.quad_wdata;
    end
    if (req.quad_rd) begin
      quad_rdata_r <= quad_mem[req.quad_addr];
    end
  end

  assign pair_rdata = pair_rdata_r;
  assign quad_rdata = quad_rdata_r;

endmodule

// ===== rtl/rgb565_box_downsample.sv =====
// Top level of the RGB565 2x2 / 4x4 box-filter downsampler.
//
// Input: one RGB565 pixel per request on in_pixel, raster order, in_valid/in_stall.
// Output: averaged pixel on out_pixel with out_row_end and out_frame_end flags,
// out_valid/out_stall. Configuration: cfg_valid/cfg_ready with cfg_index
// (0 factor mode, 1 frame width, 2 frame height) and cfg_data; cfg_ready is
// always high. Write configuration only while the block is idle.
// Throughput: one pixel per cycle while in_stall is low. The upper-row line store
// is read when the even pixel of a pair is taken and used by the odd pixel, so
// every pixel is at most a single read or write of synchronous memory with a registered read.
// Output is registered: out_valid rises in the cycle after the pixel that completes a block is taken.
// Only pixels that complete a block produce a result; others never stall.
// When the receiver stalls with a result held, in_stall rises only for a
// pixel that would produce another result.
// Reset clears counters, holds and output valid, and sets mode 2x2, 640x400.
// The line stores are not cleared; every entry is written before it is read.
`timescale 1ns / 1ps
module rgb565_box_downsample
  import rbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_pixel,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_pixel,
  output logic                 out_row_end,
  output logic                 out_frame_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  logic             factor_mode_r;
  logic [DIM_W-1:0] frame_width_r;
  logic [DIM_W-1:0] frame_height_r;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  pix_t             left_hold_r, left_hold_nxt;
  pix_t             quad_hold_r, quad_hold_nxt;
  logic             out_valid_r, out_valid_nxt;
  pix_t             out_pixel_r, out_pixel_nxt;
  logic             out_row_end_r, out_row_end_nxt;
  logic             out_frame_end_r, out_frame_end_nxt;

  logic [DIM_W-1:0] w, h, cw, ch, mask;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic             in_crop, emit_now, in_fire;
  sum_t             ps, qs, pair_rdata, quad_rdata;
  pix_t             q, res;
  rbd_store_req_t   req;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_mode_r  <= 1'b0;
      frame_width_r  <= DIM_W'(640);
      frame_height_r <= DIM_W'(400);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FACTOR_MODE:  factor_mode_r  <= cfg_data[0];
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w    = clamp_dim(frame_width_r, MAX_W_DIM);
  assign h    = clamp_dim(frame_height_r, MAX_H_DIM);
  assign mask = factor_mode_r ? DIM_W'(3) : DIM_W'(1);
  assign cw   = w & ~mask;
  assign ch   = h & ~mask;

  assign in_crop  = (DIM_W'(col_r) < cw) && (DIM_W'(row_r) < ch);
  assign emit_now = in_crop && col_r[0] && row_r[0] &&
                    (!factor_mode_r || (col_r[1] && row_r[1]));
  assign in_stall = out_valid_r && out_stall && emit_now;
  assign in_fire  = in_valid && !in_stall;

  assign ps  = pair_sum(left_hold_r, in_pixel);
  assign q   = quad_average(pair_rdata, ps);
  assign qs  = pair_sum(quad_hold_r, q);
  assign res = factor_mode_r ? quad_average(quad_rdata, qs) : q;

  always_comb begin
    req            = '0;
    req.pair_addr  = col_r[COL_W-1:1];
    req.pair_wdata = ps;
    req.quad_addr  = col_r[COL_W-1:2];
    req.quad_wdata = qs;
    left_hold_nxt  = left_hold_r;
    quad_hold_nxt  = quad_hold_r;
    if (in_fire && in_crop) begin
      if (!col_r[0]) begin
        left_hold_nxt = in_pixel;
        req.pair_rd   = row_r[0];
        req.quad_rd   = factor_mode_r && row_r[0] && row_r[1] && col_r[1];
      end else if (!row_r[0]) begin
        req.pair_wr = 1'b1;
      end else if (factor_mode_r) begin
        if (!col_r[1]) begin
          quad_hold_nxt = q;
        end else if (!row_r[1]) begin
          req.quad_wr = 1'b1;
        end
      end
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    col_inc = DIM_W'(col_r) + DIM_W'(1);
    row_inc = DIM_W'(row_r) + DIM_W'(1);
    if (in_fire) begin
      if (col_inc >= w) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_comb begin
    out_valid_nxt     = out_valid_r && out_stall;
    out_pixel_nxt     = out_pixel_r;
    out_row_end_nxt   = out_row_end_r;
    out_frame_end_nxt = out_frame_end_r;
    if (in_fire && emit_now) begin
      out_valid_nxt     = 1'b1;
      out_pixel_nxt     = res;
      out_row_end_nxt   = (DIM_W'(col_r) == cw - DIM_W'(1));
      out_frame_end_nxt = out_row_end_nxt && (DIM_W'(row_r) == ch - DIM_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      left_hold_r <= '0;
      quad_hold_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      left_hold_r <= left_hold_nxt;
      quad_hold_r <= quad_hold_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pixel_r     <= out_pixel_nxt;
    out_row_end_r   <= out_row_end_nxt;
    out_frame_end_r <= out_frame_end_nxt;
  end

  rbd_line_stores u_stores (
    .clk        (clk),
    .req        (req),
    .pair_rdata (pair_rdata),
    .quad_rdata (quad_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_pixel     = out_pixel_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled with output free");

  a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && emit_now) |=> out_valid_r)
    else $error("result lost");

  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_row_end_r || !out_frame_end_r))
    else $error("frame end without row end");

  a_pair_store_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.pair_wr && req.pair_rd) && !(req.quad_wr && req.quad_rd))
    else $error("line store read and write in one cycle");

endmodule
